/* design/efr_pkg.sv */
// Package for the event frame receiver: constants, codes and shared types.
package efr_pkg;

   localparam int HEADER_LEN = 18;
   localparam int POS_W = 5;
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(HEADER_LEN - 1);
   localparam int SKIP_W = 24;
   localparam logic [SKIP_W-1:0] SKIP_LIMIT_RESET = 24'd65536;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_MAGIC     = 2'd0,
      CSR_FRAME_VERSION   = 2'd1,
      CSR_EVENT_TYPE_CODE = 2'd2,
      CSR_SKIP_LIMIT      = 2'd3
   } csr_reg_type;

   typedef enum logic [2:0] {
      STATUS_EVENT     = 3'd0,
      STATUS_BAD_HDR   = 3'd1,
      STATUS_SKIPPED   = 3'd2,
      STATUS_OVERSIZE  = 3'd3,
      STATUS_DISCARDED = 3'd4
   } status_type;

   typedef struct packed {
      logic [31:0]       frame_magic;
      logic [7:0]        frame_version;
      logic [7:0]        event_type_code;
      logic [SKIP_W-1:0] skip_limit;
   } cfg_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  button_num;
      logic [7:0]  button_state;
      logic [31:0] sequence_res;
      logic [7:0]  frame_type;
   } result_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } queue_stat_type;

endpackage

/* design/efr_req_if.sv */
// Input byte channel: one received byte and its new-connection mark per word.
interface efr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       new_connection;

   modport source (output valid, output rx_byte, output new_connection, input ready);
   modport sink   (input valid, input rx_byte, input new_connection, output ready);
endinterface

/* design/efr_rsp_if.sv */
// Result channel: one header status word per completed header.
interface efr_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [7:0]  button_num;
   logic [7:0]  button_state;
   logic [31:0] sequence_res;
   logic [7:0]  frame_type;

   modport source (output valid, output status, output button_num, output button_state,
                   output sequence_res, output frame_type, input ready);
   modport sink   (input valid, input status, input button_num, input button_state,
                   input sequence_res, input frame_type, output ready);
endinterface

/* design/event_frame_receiver_core.sv */
// Top level of the event frame receiver: register file, front end, queue, output stage.
//
//  channel | direction | words
//  req     | in        | rx_byte, new_connection: one stream byte
//  rsp     | out       | status, button_num, button_state, sequence_res, frame_type
//  csr     | in        | csr_we, csr_index, csr_wdata: register write
//
// One byte per cycle while the result queue has room; the last header byte is classified in the cycle it is taken.
// A result passes through the result queue and then the response register before it reaches rsp.
// req stalls only when the two-entry result queue is full.
// Reset clears the parser state and the queue; registers return to their reset values.
module event_frame_receiver_core (
   input  logic                             clock,
   input  logic                             reset,
   efr_req_if.sink                          req,
   efr_rsp_if.source                        rsp,
   input  logic                             csr_we,
   input  logic [efr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [efr_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import efr_pkg::*;

   cfg_type        cfg_ff, cfg_in;
   queue_stat_type q_stat;
   logic           push;
   logic           pop;
   result_type     push_word;
   result_type     head_word;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_MAGIC:     cfg_in.frame_magic     = csr_wdata;
            CSR_FRAME_VERSION:   cfg_in.frame_version   = csr_wdata[7:0];
            CSR_EVENT_TYPE_CODE: cfg_in.event_type_code = csr_wdata[7:0];
            CSR_SKIP_LIMIT:      cfg_in.skip_limit      = csr_wdata[SKIP_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_magic     <= '0;
         cfg_ff.frame_version   <= '0;
         cfg_ff.event_type_code <= '0;
         cfg_ff.skip_limit      <= SKIP_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   efr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .cfg       (cfg_ff),
      .q_stat    (q_stat),
      .push      (push),
      .push_word (push_word)
   );

   efr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .pop       (pop),
      .head_word (head_word),
      .q_stat    (q_stat)
   );

   efr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_word (head_word),
      .q_stat    (q_stat),
      .pop       (pop),
      .rsp       (rsp)
   );

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_stat.full)
      else $error("result pushed into a full queue");

   a_pop_data: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_stat.not_empty)
      else $error("result popped from an empty queue");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      q_stat.full |-> !req.ready)
      else $error("byte taken while the queue is full");

   a_button_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status != STATUS_EVENT) |-> (rsp.button_num == 8'd0
                                                     && rsp.button_state == 8'd0))
      else $error("button fields set on a non-event word");
endmodule

/* design/efr_front.sv */
// Front end: takes bytes, gathers the header fields and classifies each header.
module efr_front (
   input  logic                   clock,
   input  logic                   reset,
   efr_req_if.sink                req,
   input  efr_pkg::cfg_type       cfg,
   input  efr_pkg::queue_stat_type q_stat,
   output logic                   push,
   output efr_pkg::result_type    push_word
);
   import efr_pkg::*;

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [SKIP_W-1:0] skip_ff, skip_in;
   logic              drop_ff, drop_in;
   logic [31:0]       magic_ff, magic_in;
   logic [7:0]        version_ff, version_in;
   logic [7:0]        type_ff, type_in;
   logic [31:0]       seq_ff, seq_in;
   logic [7:0]        width_lo_ff, width_lo_in;
   logic [7:0]        height_lo_ff, height_lo_in;
   logic [SKIP_W-1:0] plen_ff, plen_in;

   logic              accept;
   logic [POS_W-1:0]  pos;
   logic [SKIP_W-1:0] skip;
   logic              dropped;
   logic [7:0]        b;

   assign req.ready = !q_stat.full;
   assign accept    = req.valid && req.ready;
   assign b         = req.rx_byte;
   assign pos       = req.new_connection ? '0 : pos_ff;
   assign skip      = req.new_connection ? '0 : skip_ff;
   assign dropped   = req.new_connection ? 1'b0 : drop_ff;

   always_comb begin
      pos_in       = pos_ff;
      skip_in      = skip_ff;
      drop_in      = drop_ff;
      magic_in     = magic_ff;
      version_in   = version_ff;
      type_in      = type_ff;
      seq_in       = seq_ff;
      width_lo_in  = width_lo_ff;
      height_lo_in = height_lo_ff;
      plen_in      = plen_ff;
      push         = 1'b0;
      push_word.status       = STATUS_EVENT;
      push_word.button_num   = '0;
      push_word.button_state = '0;
      push_word.sequence_res = seq_ff;
      push_word.frame_type   = type_ff;
      if (accept) begin
         pos_in  = pos;
         skip_in = skip;
         drop_in = dropped;
         if (!dropped) begin
            if (skip != '0) begin
               skip_in = skip - 1'b1;
            end else begin
               unique case (pos)
                  5'd0:  magic_in[7:0]   = b;
                  5'd1:  magic_in[15:8]  = b;
                  5'd2:  magic_in[23:16] = b;
                  5'd3:  magic_in[31:24] = b;
                  5'd4:  version_in      = b;
                  5'd5:  type_in         = b;
                  5'd6:  seq_in[7:0]     = b;
                  5'd7:  seq_in[15:8]    = b;
                  5'd8:  seq_in[23:16]   = b;
                  5'd9:  seq_in[31:24]   = b;
                  5'd10: width_lo_in     = b;
                  5'd12: height_lo_in    = b;
                  5'd14: plen_in[7:0]    = b;
                  5'd15: plen_in[15:8]   = b;
                  5'd16: plen_in[23:16]  = b;
                  default: ;
               endcase
               if (pos == LAST_POS) begin
                  pos_in = '0;
                  push   = 1'b1;
                  priority if (magic_ff != cfg.frame_magic
                               || version_ff != cfg.frame_version) begin
                     push_word.status = STATUS_BAD_HDR;
                     drop_in          = 1'b1;
                  end else if (type_ff != cfg.event_type_code) begin
                     if (b == 8'd0 && plen_ff <= cfg.skip_limit) begin
                        push_word.status = STATUS_SKIPPED;
                        skip_in          = plen_ff;
                     end else begin
                        push_word.status = STATUS_OVERSIZE;
                        drop_in          = 1'b1;
                     end
                  end else if (b != 8'd0 || plen_ff != '0) begin
                     push_word.status = STATUS_DISCARDED;
                  end else begin
                     push_word.status       = STATUS_EVENT;
                     push_word.button_num   = width_lo_ff;
                     push_word.button_state = height_lo_ff;
                  end
               end else begin
                  pos_in = pos + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         skip_ff <= '0;
         drop_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         skip_ff <= skip_in;
         drop_ff <= drop_in;
      end
      magic_ff     <= magic_in;
      version_ff   <= version_in;
      type_ff      <= type_in;
      seq_ff       <= seq_in;
      width_lo_ff  <= width_lo_in;
      height_lo_ff <= height_lo_in;
      plen_ff      <= plen_in;
   end
endmodule

/* design/efr_queue.sv */
// Two-entry result queue between the front end and the output stage.
module efr_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  efr_pkg::result_type     push_word,
   input  logic                    pop,
   output efr_pkg::result_type     head_word,
   output efr_pkg::queue_stat_type q_stat
);
   import efr_pkg::*;

   result_type        data_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign q_stat.not_empty = count_ff != '0;
   assign q_stat.full      = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign head_word        = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         data_ff[wr_ptr_ff] <= push_word;
      end
   end
endmodule

/* design/efr_back.sv */
// Output stage: moves queued results into the response register.
module efr_back (
   input  logic                    clock,
   input  logic                    reset,
   input  efr_pkg::result_type     head_word,
   input  efr_pkg::queue_stat_type q_stat,
   output logic                    pop,
   efr_rsp_if.source               rsp
);
   import efr_pkg::*;

   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;

   assign pop = q_stat.not_empty && (!out_valid_ff || rsp.ready);

   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      if (pop) begin
         out_in       = head_word;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_ff <= out_in;
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.status       = out_ff.status;
   assign rsp.button_num   = out_ff.button_num;
   assign rsp.button_state = out_ff.button_state;
   assign rsp.sequence_res = out_ff.sequence_res;
   assign rsp.frame_type   = out_ff.frame_type;
endmodule

/* tb/event_frame_receiver_core_tb.sv */
// Testbench for the event frame receiver: byte-stream stimulus, header predictor, result checker.
`timescale 1ns / 100ps

module event_frame_receiver_core_tb;
   import efr_pkg::*;

   localparam int IDLE_LIMIT      = 3000;
   localparam int RSP_HOLD_CYCLES = 400;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   efr_req_if req_if();
   efr_rsp_if rsp_if();

   event_frame_receiver_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // header parser shadow
   cfg_type           cfg_shadow;
   logic [7:0]        hdr_store [HEADER_LEN];
   logic [POS_W-1:0]  hdr_pos;
   logic [SKIP_W-1:0] skip_left;
   logic              link_down;
   result_type        pending_status[$];

   int  errors;
   int  results_checked;
   int  bytes_sent;
   int  status_seen [5];
   int  idle_cycles;
   logic moved;
   logic req_gaps_on;
   logic rsp_stalls_on;
   logic rsp_hold_req;
   logic need_fresh;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void parse_rx_byte(input logic [7:0] rx, input logic fresh);
      result_type  word;
      logic [31:0] magic;
      logic [31:0] plen;
      if (fresh) begin
         hdr_pos   = '0;
         skip_left = '0;
         link_down = 1'b0;
      end
      if (link_down) return;
      if (skip_left != '0) begin
         skip_left = skip_left - 1'b1;
         return;
      end
      hdr_store[hdr_pos] = rx;
      hdr_pos = hdr_pos + 1'b1;
      if (hdr_pos < HEADER_LEN) return;
      hdr_pos = '0;

      magic = {hdr_store[3], hdr_store[2], hdr_store[1], hdr_store[0]};
      plen  = {hdr_store[17], hdr_store[16], hdr_store[15], hdr_store[14]};
      word.button_num   = 8'h00;
      word.button_state = 8'h00;
      word.sequence_res = {hdr_store[9], hdr_store[8], hdr_store[7], hdr_store[6]};
      word.frame_type   = hdr_store[5];
      if (magic != cfg_shadow.frame_magic || hdr_store[4] != cfg_shadow.frame_version) begin
         word.status = STATUS_BAD_HDR;
         link_down   = 1'b1;
      end else if (hdr_store[5] != cfg_shadow.event_type_code) begin
         if (plen <= {8'h00, cfg_shadow.skip_limit}) begin
            word.status = STATUS_SKIPPED;
            skip_left   = plen[SKIP_W-1:0];
         end else begin
            word.status = STATUS_OVERSIZE;
            link_down   = 1'b1;
         end
      end else if (plen != 32'd0) begin
         word.status = STATUS_DISCARDED;
      end else begin
         word.status       = STATUS_EVENT;
         word.button_num   = hdr_store[10];
         word.button_state = hdr_store[12];
      end
      pending_status.push_back(word);
   endfunction

   function automatic void check_status_word();
      result_type want;
      if (pending_status.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("%0t: unexpected result: status %0d seq %h type %h", $realtime,
                     rsp_if.status, rsp_if.sequence_res, rsp_if.frame_type);
         return;
      end
      want = pending_status.pop_front();
      results_checked++;
      status_seen[int'(want.status)]++;
      if (rsp_if.status != want.status || rsp_if.button_num != want.button_num ||
          rsp_if.button_state != want.button_state ||
          rsp_if.sequence_res != want.sequence_res || rsp_if.frame_type != want.frame_type) begin
         errors++;
         if (errors <= 10)
            $display({"%0t: mismatch: exp st %0d id %h bs %h seq %h ty %h",
                      " / got st %0d id %h bs %h seq %h ty %h"},
                     $realtime, want.status, want.button_num, want.button_state,
                     want.sequence_res, want.frame_type, rsp_if.status, rsp_if.button_num,
                     rsp_if.button_state, rsp_if.sequence_res, rsp_if.frame_type);
      end
   endfunction

   // sample both channels at the edge where words move
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         moved = 1'b0;
         if (req_if.valid && req_if.ready) begin
            parse_rx_byte(req_if.rx_byte, req_if.new_connection);
            moved = 1'b1;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            check_status_word();
            moved = 1'b1;
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
      end
   end

   initial begin
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
      $display("FAILED: results differ");
      $finish;
   end

   // result sink: random stalls, plus one long hold-off on request
   initial begin
      rsp_if.ready = 1'b0;
      @(posedge clock);
      forever begin
         if (rsp_hold_req) begin
            rsp_if.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            rsp_hold_req = 1'b0;
         end else if (rsp_stalls_on && $urandom_range(0, 3) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap_len()) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic send_byte(input logic [7:0] rx, input logic fresh);
      int gap;
      gap = 0;
      if (req_gaps_on && $urandom_range(0, 3) == 0) gap = gap_len();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.rx_byte        <= rx;
      req_if.new_connection <= fresh;
      do @(posedge clock); while (!req_if.ready);
      bytes_sent++;
   endtask

   task automatic send_header(input logic [31:0] magic, input logic [7:0] ver,
                              input logic [7:0] typ, input logic [31:0] seq,
                              input logic [15:0] w, input logic [15:0] h,
                              input logic [31:0] plen, input logic fresh,
                              input int nbytes = HEADER_LEN);
      logic [8*HEADER_LEN-1:0] raw;
      raw = {plen, h, w, seq, typ, ver, magic};
      for (int i = 0; i < nbytes; i++)
         send_byte(raw[8*i +: 8], (i == 0) ? fresh : 1'b0);
   endtask

   task automatic send_noise(input int n, input logic allow_fresh);
      for (int i = 0; i < n; i++)
         send_byte(8'($urandom), allow_fresh && $urandom_range(0, 7) == 0);
   endtask

   task automatic send_event(input logic fresh);
      send_header(cfg_shadow.frame_magic, cfg_shadow.frame_version,
                  cfg_shadow.event_type_code, $urandom, 16'($urandom), 16'($urandom),
                  32'd0, fresh);
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_status.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_reg(input csr_reg_type idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_FRAME_MAGIC:     cfg_shadow.frame_magic     = value;
         CSR_FRAME_VERSION:   cfg_shadow.frame_version   = value[7:0];
         CSR_EVENT_TYPE_CODE: cfg_shadow.event_type_code = value[7:0];
         CSR_SKIP_LIMIT:      cfg_shadow.skip_limit      = value[SKIP_W-1:0];
         default: ;
      endcase
   endtask

   task automatic load_config(input logic [31:0] magic, input logic [7:0] ver,
                              input logic [7:0] evt, input logic [SKIP_W-1:0] lim);
      write_reg(CSR_FRAME_MAGIC, magic);
      write_reg(CSR_FRAME_VERSION, {24'h0, ver});
      write_reg(CSR_EVENT_TYPE_CODE, {24'h0, evt});
      write_reg(CSR_SKIP_LIMIT, {8'h0, lim});
   endtask

   // registers at reset: all-zero magic, version and event type, 64 KiB skip limit
   task automatic test_reset_defaults();
      send_header(32'h0, 8'h00, 8'h00, 32'h0000_0001, 16'h00AB, 16'h00CD, 32'd0, 1'b1);
      send_header(32'h0, 8'h00, 8'h07, 32'h0000_0002, 16'h0, 16'h0, 32'd3, 1'b0);
      send_noise(3, 1'b0);
      send_header(32'h0, 8'h00, 8'h07, 32'h0000_0003, 16'h0, 16'h0, 32'd65537, 1'b0);
      send_noise(4, 1'b0);
      send_event(1'b1);
      wait_idle();
   endtask

   task automatic test_directed_cases();
      logic [31:0] m;
      logic [7:0]  v;
      logic [7:0]  e;
      load_config(32'hA5C3_0F01, 8'h5A, 8'h81, 24'd20);
      m = cfg_shadow.frame_magic;
      v = cfg_shadow.frame_version;
      e = cfg_shadow.event_type_code;
      send_header(m, v, e, 32'hFFFF_FFFF, 16'hFFFF, 16'h0000, 32'd0, 1'b1);
      send_header(m, v, e, 32'h0000_0000, 16'h1200, 16'h34FF, 32'd0, 1'b0);
      // event with payload: following bytes are taken as the next header
      send_header(m, v, e, 32'h1111_1111, 16'h0001, 16'h0002, 32'd1, 1'b0);
      send_event(1'b0);
      send_header(m, v, e, 32'h2222_2222, 16'h0, 16'h0, 32'hFFFF_FFFF, 1'b0);
      send_header(m, v, 8'h00, 32'h3333_3333, 16'h0, 16'h0, 32'd0, 1'b0);
      send_header(m, v, 8'hFF, 32'h4444_4444, 16'h0, 16'h0, 32'd20, 1'b0);
      send_noise(20, 1'b0);
      send_event(1'b0);
      send_header(m, v, 8'h7E, 32'h5555_5555, 16'h0, 16'h0, 32'd21, 1'b0);
      send_noise(5, 1'b0);
      send_event(1'b1);
      send_header(m, v, 8'h01, 32'h6666_6666, 16'h0, 16'h0, 32'hFFFF_FFFF, 1'b0);
      send_event(1'b1);
      send_header(m ^ 32'h8000_0000, v, e, 32'h7777_7777, 16'h0, 16'h0, 32'd0, 1'b0);
      send_noise(6, 1'b0);
      send_event(1'b1);
      send_header(m, v ^ 8'h01, e, 32'h8888_8888, 16'h0, 16'h0, 32'd0, 1'b0);
      send_event(1'b1);
      // new connection mid-header and mid-skip
      send_header(m, v, e, 32'h9999_9999, 16'h0, 16'h0, 32'd0, 1'b0, 7);
      send_event(1'b1);
      send_header(m, v, 8'h02, 32'hAAAA_AAAA, 16'h0, 16'h0, 32'd15, 1'b0);
      send_noise(5, 1'b0);
      send_event(1'b1);
      wait_idle();
   endtask

   task automatic test_random_traffic(input int n_bytes);
      int          stop;
      int          sel;
      int          cap;
      logic        fresh;
      logic [31:0] plen;
      logic [7:0]  typ;
      stop = bytes_sent + n_bytes;
      need_fresh = 1'b1;
      while (bytes_sent < stop) begin
         sel   = $urandom_range(0, 99);
         fresh = need_fresh || $urandom_range(0, 9) == 0;
         need_fresh = 1'b0;
         typ   = cfg_shadow.event_type_code ^ 8'($urandom_range(1, 255));
         if (sel < 45) begin
            send_event(fresh);
         end else if (sel < 55) begin
            plen = $urandom_range(0, 1) ? 32'($urandom_range(1, 40)) : ($urandom | 32'd1);
            send_header(cfg_shadow.frame_magic, cfg_shadow.frame_version,
                        cfg_shadow.event_type_code, $urandom, 16'($urandom),
                        16'($urandom), plen, fresh);
         end else if (sel < 70) begin
            cap  = (cfg_shadow.skip_limit < 12) ? int'(cfg_shadow.skip_limit) : 12;
            plen = $urandom_range(0, cap);
            send_header(cfg_shadow.frame_magic, cfg_shadow.frame_version, typ, $urandom,
                        16'($urandom), 16'($urandom), plen, fresh);
            send_noise(int'(plen), 1'b0);
         end else if (sel < 75) begin
            plen = {8'h00, cfg_shadow.skip_limit} + 32'd1;
            if ($urandom_range(0, 1)) plen = plen + ($urandom % (32'hFFFF_FFFF - plen + 1));
            send_header(cfg_shadow.frame_magic, cfg_shadow.frame_version, typ, $urandom,
                        16'($urandom), 16'($urandom), plen, fresh);
            send_noise($urandom_range(0, 6), 1'b0);
            need_fresh = 1'b1;
         end else if (sel < 83) begin
            if ($urandom_range(0, 1))
               send_header(cfg_shadow.frame_magic ^ (32'd1 << $urandom_range(0, 31)),
                           cfg_shadow.frame_version, cfg_shadow.event_type_code, $urandom,
                           16'($urandom), 16'($urandom), 32'd0, fresh);
            else
               send_header(cfg_shadow.frame_magic,
                           cfg_shadow.frame_version ^ 8'($urandom_range(1, 255)),
                           typ, $urandom, 16'($urandom), 16'($urandom), $urandom, fresh);
            send_noise($urandom_range(0, 6), 1'b0);
            need_fresh = 1'b1;
         end else if (sel < 91) begin
            send_noise($urandom_range(1, 10), 1'b1);
            need_fresh = 1'b1;
         end else begin
            send_header(cfg_shadow.frame_magic, cfg_shadow.frame_version,
                        cfg_shadow.event_type_code, $urandom, 16'($urandom),
                        16'($urandom), 32'd0, fresh, $urandom_range(1, HEADER_LEN - 1));
            need_fresh = 1'b1;
         end
      end
      wait_idle();
   endtask

   // sink holds off while the source keeps offering back-to-back headers
   task automatic test_backpressure();
      req_gaps_on  = 1'b0;
      rsp_hold_req = 1'b1;
      repeat (2) @(posedge clock);
      send_event(1'b1);
      repeat (9) send_event(1'b0);
      wait_idle();
      req_gaps_on = 1'b1;
   endtask

   initial begin
      reset                 = 1'b1;
      req_if.valid          = 1'b0;
      req_if.rx_byte        = 8'h00;
      req_if.new_connection = 1'b0;
      csr_we                = 1'b0;
      csr_index             = CSR_FRAME_MAGIC;
      csr_wdata             = '0;
      cfg_shadow            = '{frame_magic: 32'h0, frame_version: 8'h0,
                                event_type_code: 8'h0, skip_limit: SKIP_LIMIT_RESET};
      hdr_pos       = '0;
      skip_left     = '0;
      link_down     = 1'b0;
      errors        = 0;
      results_checked = 0;
      bytes_sent    = 0;
      status_seen   = '{default: 0};
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
      rsp_hold_req  = 1'b0;
      need_fresh    = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_directed_cases();
      test_random_traffic(200);

      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      load_config(32'hFFFF_FFFF, 8'hFF, 8'hFF, 24'hFF_FFFF);
      test_random_traffic(175);

      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
      load_config(32'h0, 8'h00, 8'h00, 24'h0);
      test_random_traffic(175);

      test_backpressure();

      load_config($urandom, 8'($urandom), 8'($urandom), 24'($urandom_range(1, 16)));
      test_random_traffic(175);

      $display("Sent %0d stream bytes over five register settings; checked %0d header results",
               bytes_sent, results_checked);
      $display("  event %0d, bad header %0d, skipped %0d, oversize %0d, discarded %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
      if (errors == 0 && pending_status.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
